// ===== rtl/saslprep_code_point_mapper_unit_macros.svh =====
// Assertion helpers shared by the mapper RTL
`ifndef SASLPREP_CODE_POINT_MAPPER_UNIT_MACROS_SVH
`define SASLPREP_CODE_POINT_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("saslprep mapper: same-cycle check failed");

// next-cycle implication
`define SCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("saslprep mapper: next-cycle check failed");

`else

`define SCM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SCM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/saslp_pkg.sv =====
package saslp_pkg;

   localparam int CP_W      = 21;
   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 4;
   localparam int CNT_W     = 3;

   localparam logic [1:0] ESC_REMOVE = 2'd0;
   localparam logic [1:0] ESC_COMMA  = 2'd1;
   localparam logic [1:0] ESC_EQUALS = 2'd2;

   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_EQUALS = 8'h3D;
   localparam logic [BYTE_W-1:0] CHR_TWO    = 8'h32;
   localparam logic [BYTE_W-1:0] CHR_THREE  = 8'h33;
   localparam logic [BYTE_W-1:0] CHR_UPPER_C = 8'h43;
   localparam logic [BYTE_W-1:0] CHR_UPPER_D = 8'h44;

   localparam logic [CP_W-1:0] CP_LAST_VALID = 21'h10FFFF;

   localparam int DROP_RANGES = 21;

   localparam logic [CP_W-1:0] DROP_LO [DROP_RANGES] = '{
      21'h00000, 21'h0007F, 21'h00340, 21'h006DD, 21'h0070F, 21'h0180E,
      21'h0200C, 21'h02028, 21'h02060, 21'h0206A, 21'h02FF0, 21'h0D800,
      21'h0E000, 21'h0FDD0, 21'h0FEFF, 21'h0FFF9, 21'h1D173, 21'hE0001,
      21'hE0020, 21'hF0000, 21'h100000
   };

   localparam logic [CP_W-1:0] DROP_HI [DROP_RANGES] = '{
      21'h0001F, 21'h0009F, 21'h00341, 21'h006DD, 21'h0070F, 21'h0180E,
      21'h0200F, 21'h0202E, 21'h02063, 21'h0206F, 21'h02FFB, 21'h0DFFF,
      21'h0F8FF, 21'h0FDEF, 21'h0FEFF, 21'h0FFFF, 21'h1D17A, 21'hE0001,
      21'hE007F, 21'hFFFFD, 21'h10FFFD
   };

   // bytes in emission order, entry 0 first
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
   } class_type;

   typedef struct packed {
      logic             can_load;
      logic [CNT_W-1:0] remaining;
   } emit_status_type;

endpackage

// ===== rtl/saslp_classify.sv =====
module saslp_classify
   import saslp_pkg::*;
(
   input  logic [CP_W-1:0] code_point,
   input  logic [1:0]      escape_mode,
   output class_type       result
);

   logic printable;
   logic space_like;
   logic in_table;
   logic dropped;

   always_comb begin
      in_table = 1'b0;
      for (int i = 0; i < DROP_RANGES; i++) begin
         if (code_point >= DROP_LO[i] && code_point <= DROP_HI[i]) begin
            in_table = 1'b1;
         end
      end
   end

   assign printable  = (code_point >= 21'h00020) && (code_point < 21'h0007F);
   assign space_like = ((code_point >= 21'h02000) && (code_point <= 21'h0200B)) ||
                       (code_point == 21'h000A0) || (code_point == 21'h01680) ||
                       (code_point == 21'h0202F) || (code_point == 21'h0205F) ||
                       (code_point == 21'h03000);
   // plane noncharacters xFFFE/xFFFF
   assign dropped    = (code_point > CP_LAST_VALID) || (&code_point[15:1]) || in_table;

   always_comb begin
      result.bytes = '0;
      result.count = 3'd0;
      if (printable) begin
         if (code_point[7:0] == CHR_COMMA &&
             (escape_mode == ESC_COMMA || escape_mode == ESC_EQUALS)) begin
            result.bytes[0] = CHR_EQUALS;
            result.bytes[1] = CHR_TWO;
            result.bytes[2] = CHR_UPPER_C;
            result.count    = 3'd3;
         end else if (code_point[7:0] == CHR_EQUALS && escape_mode == ESC_EQUALS) begin
            result.bytes[0] = CHR_EQUALS;
            result.bytes[1] = CHR_THREE;
            result.bytes[2] = CHR_UPPER_D;
            result.count    = 3'd3;
         end else begin
            result.bytes[0] = code_point[7:0];
            result.count    = 3'd1;
         end
      end else if (space_like) begin
         result.bytes[0] = CHR_SPACE;
         result.count    = 3'd1;
      end else if (!dropped) begin
         if (code_point < 21'h00800) begin
            result.bytes[0] = {3'b110, code_point[10:6]};
            result.bytes[1] = {2'b10, code_point[5:0]};
            result.count    = 3'd2;
         end else if (code_point < 21'h10000) begin
            result.bytes[0] = {4'b1110, code_point[15:12]};
            result.bytes[1] = {2'b10, code_point[11:6]};
            result.bytes[2] = {2'b10, code_point[5:0]};
            result.count    = 3'd3;
         end else begin
            result.bytes[0] = {5'b11110, code_point[20:18]};
            result.bytes[1] = {2'b10, code_point[17:12]};
            result.bytes[2] = {2'b10, code_point[11:6]};
            result.bytes[3] = {2'b10, code_point[5:0]};
            result.count    = 3'd4;
         end
      end
   end

endmodule

// ===== rtl/saslp_emit.sv =====
module saslp_emit
   import saslp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  class_type         load_data,
   output emit_status_type   status,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte
);

   logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]                 rem_ff, rem_in;
   logic                             strobe_ff, strobe_in;
   logic [BYTE_W-1:0]                byte_ff, byte_in;
   logic                             last_ff, last_in;
   logic                             can_load;

   // free now when idle or when the last byte is being registered out this cycle
   assign can_load = (rem_ff <= 3'd1);

   always_comb begin
      strobe_in = (rem_ff != 3'd0);
      byte_in   = buf_ff[0];
      last_in   = (rem_ff == 3'd1);
      buf_in    = {{BYTE_W{1'b0}}, buf_ff[MAX_BYTES-1:1]};
      rem_in    = (rem_ff != 3'd0) ? rem_ff - 3'd1 : 3'd0;
      if (load_valid && can_load) begin
         buf_in = load_data.bytes;
         rem_in = load_data.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= 3'd0;
         strobe_ff <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         strobe_ff <= strobe_in;
      end
      buf_ff  <= buf_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign status.can_load  = can_load;
   assign status.remaining = rem_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_byte    = last_ff;

endmodule

// ===== rtl/saslprep_code_point_mapper_unit.sv =====
// Path: a taken start is registered in the input stage, loaded into the serialiser
// buffer, then each byte is registered onto rsp_*. Throughput: one code point per
// cycle when it maps to zero or one byte; a longer item (up to four bytes) holds the
// serialiser and can hold busy high while a following item waits in the input stage.
// Reset: synchronous, active high; clears the pipeline and sets escape_mode to 0.
// The receiver cannot stall: each byte is shown for exactly one cycle.
`include "saslprep_code_point_mapper_unit_macros.svh"

module saslprep_code_point_mapper_unit
   import saslp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CP_W-1:0]   req_code_point,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_escape_mode
);

   logic [CP_W-1:0] cp_ff, cp_in;
   logic            in_valid_ff, in_valid_in;
   logic [1:0]      mode_ff, mode_in;
   logic            accept;
   class_type       cls;
   emit_status_type emit_status;

   assign csr_ready = 1'b1;
   assign busy      = in_valid_ff && !emit_status.can_load;
   assign accept    = start && !busy;

   always_comb begin
      cp_in       = accept ? req_code_point : cp_ff;
      in_valid_in = accept || (in_valid_ff && !emit_status.can_load);
      mode_in     = (csr_valid && csr_ready) ? csr_escape_mode : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= ESC_REMOVE;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
      end
      cp_ff <= cp_in;
   end

   saslp_classify u_classify (
      .code_point  (cp_ff),
      .escape_mode (mode_ff),
      .result      (cls)
   );

   saslp_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (in_valid_ff),
      .load_data     (cls),
      .status        (emit_status),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // a taken transaction always lands in the input stage
   `SCM_ASSERT_NEXT(a_accept_held, clock, reset, accept, in_valid_ff)
   // multi-byte sequences are emitted without gaps
   `SCM_ASSERT_NEXT(a_no_gap, clock, reset, rsp_strobe && !rsp_last_byte, rsp_strobe)
   // bytes still queued in the serialiser come out next cycle
   `SCM_ASSERT_NEXT(a_queue_drains, clock, reset, emit_status.remaining != 3'd0, rsp_strobe)
   // busy only while the serialiser cannot take the staged item
   `SCM_ASSERT_NOW(a_busy_cause, clock, reset, busy, emit_status.remaining > 3'd1)

endmodule
